### sv/tkt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tkt_pkg;

  // operation codes carried by the opcode field
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // one held record
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [7:0]  grade;
    logic [7:0]  exercises;
  } entry_t;

  // control handed to every cell in the accept cycle
  typedef struct packed {
    logic   ins;          // insert word accepted
    logic   rem;          // remove word accepted
    logic   prev_take;    // cell above takes the new record or shifts down
    logic   found_above;  // a match was found above this cell
    entry_t rec;          // new record with valid set, id doubles as removal key
  } cell_ctrl_t;

  // per-cell compare results
  typedef struct packed {
    logic take;   // empty or strictly beaten by the new record
    logic match;  // holds a record with the removal key
  } cell_stat_t;

  // one result word
  typedef struct packed {
    logic [1:0]  rank;
    logic        valid;
    logic [31:0] id;
    logic [7:0]  grade;
    logic [7:0]  exercises;
    logic        last;
  } out_word_t;

endpackage

`default_nettype wire

### sv/tkt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tkt_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tkt_pkg::cell_ctrl_t ctrl,
  input  wire tkt_pkg::entry_t    above,
  input  wire tkt_pkg::entry_t    below,
  output tkt_pkg::entry_t         entry,
  output tkt_pkg::cell_stat_t     stat
);

  // local compares against the held record
  logic beats;
  assign beats = (ctrl.rec.grade > entry.grade) ||
                 ((ctrl.rec.grade == entry.grade) &&
                  (ctrl.rec.exercises > entry.exercises));
  assign stat = '{take:  !entry.valid || beats,
                  match: entry.valid && (entry.id == ctrl.rec.id)};

  // insert loads new or shifts down, remove shifts up from below
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (ctrl.ins) begin
      if (ctrl.prev_take) begin
        entry <= above;
      end else if (stat.take) begin
        entry <= ctrl.rec;
      end
    end else if (ctrl.rem && (stat.match || ctrl.found_above)) begin
      entry <= below;
    end
  end

endmodule

`default_nettype wire

### sv/top_k_tracker_with_removal.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake            | word
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | opcode, rec_id, rec_grade, rec_exercises
// out      | out_valid / out_ready| rank, entry_valid, entry_id, entry_grade,
//          |                      | entry_exercises, last
//
// insert and remove: every cell compares in parallel and the row shifts
// in the accept cycle, the result lands in the output register.
// read emits TOP_COUNT words from a rank counter after the accept cycle,
// one per cycle unless the output stalls; input waits until the last is loaded.
// rst clears all cells and control.
// a stalled output holds its word and blocks input until taken.

module top_k_tracker_with_removal #(
  parameter int TOP_COUNT = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] rec_id,
  input  wire logic [7:0]  rec_grade,
  input  wire logic [7:0]  rec_exercises,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       rank,
  output logic             entry_valid,
  output logic [31:0]      entry_id,
  output logic [7:0]       entry_grade,
  output logic [7:0]       entry_exercises,
  output logic             last
);

  localparam int CNT_W = $clog2(TOP_COUNT + 1);
  localparam int IDX_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

  tkt_pkg::entry_t     entries [TOP_COUNT];
  tkt_pkg::entry_t     aboves  [TOP_COUNT];
  tkt_pkg::entry_t     belows  [TOP_COUNT];
  tkt_pkg::cell_ctrl_t ctrls   [TOP_COUNT];
  tkt_pkg::cell_stat_t stats   [TOP_COUNT];
  logic [TOP_COUNT-1:0] take;
  logic [TOP_COUNT-1:0] match;
  logic [TOP_COUNT-1:0] found_above;

  logic             reading;
  logic [CNT_W-1:0] rd_cnt;
  logic             out_free;
  logic             accept;
  logic             ins_en;
  logic             rem_en;
  tkt_pkg::entry_t  new_rec;
  tkt_pkg::out_word_t out_word;
  tkt_pkg::out_word_t out_word_next;
  logic             out_load;

  // handshake
  assign out_free = !out_valid || out_ready;
  assign in_ready = !reading && out_free;
  assign accept   = in_valid && in_ready;
  assign ins_en   = accept && (tkt_pkg::op_t'(opcode) == tkt_pkg::OP_INSERT);
  assign rem_en   = accept && (tkt_pkg::op_t'(opcode) == tkt_pkg::OP_REMOVE);

  assign new_rec = '{valid: 1'b1, id: rec_id, grade: rec_grade, exercises: rec_exercises};

  // row of cells with neighbor links
  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    assign take[i]  = stats[i].take;
    assign match[i] = stats[i].match;
    if (i == 0) begin : g_head
      assign found_above[i] = 1'b0;
      assign aboves[i] = '0;
      assign ctrls[i]  = '{ins: ins_en, rem: rem_en, prev_take: 1'b0,
                           found_above: 1'b0, rec: new_rec};
    end else begin : g_body
      assign found_above[i] = found_above[i-1] || match[i-1];
      assign aboves[i] = entries[i-1];
      assign ctrls[i]  = '{ins: ins_en, rem: rem_en, prev_take: take[i-1],
                           found_above: found_above[i], rec: new_rec};
    end
    if (i == TOP_COUNT - 1) begin : g_tail
      assign belows[i] = '0;
    end else begin : g_mid
      assign belows[i] = entries[i+1];
    end
    tkt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrls[i]),
      .above (aboves[i]),
      .below (belows[i]),
      .entry (entries[i]),
      .stat  (stats[i])
    );
  end

  // rank and record of the first taking or matching cell
  logic [CNT_W-1:0]  ins_rank;
  logic [CNT_W-1:0]  rem_rank;
  tkt_pkg::entry_t   rem_entry;
  logic              ins_hit;
  logic              rem_hit;

  always_comb begin
    ins_rank  = CNT_W'(TOP_COUNT);
    rem_rank  = CNT_W'(TOP_COUNT);
    rem_entry = '0;
    ins_hit   = |take;
    rem_hit   = |match;
    if (ins_hit) ins_rank = '0;
    if (rem_hit) rem_rank = '0;
    for (int i = 0; i < TOP_COUNT; i++) begin
      if (take[i] && ((i == 0) || !take[(i == 0) ? 0 : i - 1])) begin
        ins_rank = ins_rank | CNT_W'(i);
      end
      if (match[i] && !found_above[i]) begin
        rem_rank  = rem_rank | CNT_W'(i);
        rem_entry = rem_entry | entries[i];
      end
    end
  end

  // rank masked to the two-bit field
  function automatic logic [1:0] rank2(input logic [CNT_W-1:0] r);
    logic [CNT_W+1:0] wide;
    wide = {2'b00, r};
    return wide[1:0];
  endfunction

  // next output word
  tkt_pkg::entry_t rd_entry;
  logic            rd_last;
  assign rd_entry = entries[rd_cnt[IDX_W-1:0]];
  assign rd_last  = (rd_cnt == CNT_W'(TOP_COUNT - 1));

  always_comb begin
    out_load      = 1'b0;
    out_word_next = '0;
    if (ins_en) begin
      out_load            = 1'b1;
      out_word_next.rank  = rank2(ins_rank);
      out_word_next.last  = 1'b1;
      if (ins_hit) begin
        out_word_next.valid     = 1'b1;
        out_word_next.id        = rec_id;
        out_word_next.grade     = rec_grade;
        out_word_next.exercises = rec_exercises;
      end
    end else if (rem_en) begin
      out_load            = 1'b1;
      out_word_next.rank  = rank2(rem_rank);
      out_word_next.last  = 1'b1;
      if (rem_hit) begin
        out_word_next.valid     = 1'b1;
        out_word_next.id        = rem_entry.id;
        out_word_next.grade     = rem_entry.grade;
        out_word_next.exercises = rem_entry.exercises;
      end
    end else if (reading && out_free) begin
      out_load            = 1'b1;
      out_word_next.rank  = rank2(rd_cnt);
      out_word_next.last  = rd_last;
      if (rd_entry.valid) begin
        out_word_next.valid     = 1'b1;
        out_word_next.id        = rd_entry.id;
        out_word_next.grade     = rd_entry.grade;
        out_word_next.exercises = rd_entry.exercises;
      end
    end
  end

  // control: output valid and read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      reading   <= 1'b0;
      rd_cnt    <= '0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      if (accept && (tkt_pkg::op_t'(opcode) == tkt_pkg::OP_READ)) begin
        reading <= 1'b1;
        rd_cnt  <= '0;
      end else if (reading && out_free) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
        if (rd_last) reading <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) out_word <= out_word_next;
  end

  assign rank            = out_word.rank;
  assign entry_valid     = out_word.valid;
  assign entry_id        = out_word.id;
  assign entry_grade     = out_word.grade;
  assign entry_exercises = out_word.exercises;
  assign last            = out_word.last;

endmodule

`default_nettype wire
